// ===== hdl/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg
// Types, constants and helpers of the 64-bit Feistel block cipher.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int ROUND_COUNT = 8;
   localparam int WORD_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic [WORD_WIDTH-1:0] SUBKEY_STEP = 32'h1234ABCD;

   localparam logic ACTION_ENCRYPT = 1'b0;
   localparam logic ACTION_DECRYPT = 1'b1;

   localparam logic [0:0] REG_CIPHER_KEY = 1'b0;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      logic     action;
      word_type left_half;
      word_type right_half;
   } req_payload_type;

   typedef struct packed {
      word_type left_result;
      word_type right_result;
   } rsp_payload_type;

   typedef struct packed {
      logic     valid;
      logic     action;
      word_type left_word;
      word_type right_word;
   } stage_type;

   function automatic word_type subkey_offset(input int round_idx);
      logic [63:0] product;
      product = 64'(round_idx) * 64'(SUBKEY_STEP);
      return product[WORD_WIDTH-1:0];
   endfunction

   function automatic word_type round_fn(input word_type half, input word_type subkey);
      word_type rotated;
      rotated = {half[WORD_WIDTH-4:0], half[WORD_WIDTH-1:WORD_WIDTH-3]};
      return (half ^ subkey) + rotated;
   endfunction

endpackage

// ===== hdl/fbc_round.sv =====
// ----------------------------------------------------------------------------
// fbc_round
// One registered Feistel round; direction follows the item's action bit.
// ----------------------------------------------------------------------------
module fbc_round
   import fbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  stage_type prev_stage,
   input  word_type  enc_subkey,
   input  word_type  dec_subkey,
   output stage_type next_stage
);

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;
   word_type  f_value;

   always_comb begin
      data_in = prev_stage;
      if (prev_stage.action == ACTION_DECRYPT) begin
         f_value = round_fn(prev_stage.left_word, dec_subkey);
         data_in.left_word = prev_stage.right_word ^ f_value;
         data_in.right_word = prev_stage.left_word;
      end else begin
         f_value = round_fn(prev_stage.right_word, enc_subkey);
         data_in.left_word = prev_stage.right_word;
         data_in.right_word = prev_stage.left_word ^ f_value;
      end
      valid_in = enable ? prev_stage.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      next_stage = data_ff;
      next_stage.valid = valid_ff;
   end

endmodule

// ===== hdl/feistel_block_cipher_64.sv =====
// ----------------------------------------------------------------------------
// feistel_block_cipher_64
// Pipelined 8-round Feistel cipher on 64-bit blocks under a 32-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: an item carries action (0 encrypt, 1 decrypt) and
//   the two block halves; it is taken when req_valid is high and req_stall
//   low. Result channel rsp_*: the processed halves, taken when rsp_valid
//   is high and rsp_stall low.
//   Configuration: APB-style port, cipher_key at byte address 0; pready is
//   always high. Write the key only while no item is in flight.
//   Pipeline: an accepted item passes through the round registers in order,
//   and rsp_valid rises when it reaches the last of them. One register stage
//   per round, each holding one 32-bit add and two 32-bit XORs.
//   Throughput: one item per cycle while the receiver does not stall.
//   Stall: while a result waits with rsp_stall high the whole pipeline
//   holds and req_stall is raised; nothing is lost or repeated.
//   Reset: synchronous; clears all stage valid bits and the key to zero.
// ----------------------------------------------------------------------------
module feistel_block_cipher_64
   import fbc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [WORD_WIDTH-1:0]     pwdata,
   output logic [WORD_WIDTH-1:0]     prdata,
   output logic                      pready
);

   word_type  key_ff;
   word_type  key_in;
   logic      enable;
   stage_type entry_stage;
   stage_type stages [ROUND_COUNT];
   logic [ROUND_COUNT-1:0] stage_valid;
   logic      csr_write;
   logic [0:0] csr_index;

   assign pready = 1'b1;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1:CSR_ADDR_WIDTH-1];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      key_in = key_ff;
      if (csr_write && csr_index == REG_CIPHER_KEY) begin
         key_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == REG_CIPHER_KEY) begin
         prdata = key_ff;
      end
   end

   // advance when the output slot is empty or being taken
   assign enable = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   always_comb begin
      entry_stage.valid = req_valid;
      entry_stage.action = req_payload.action;
      entry_stage.left_word = req_payload.left_half;
      entry_stage.right_word = req_payload.right_half;
   end

   for (genvar s = 0; s < ROUND_COUNT; s++) begin : g_round
      localparam word_type ENC_OFFSET = subkey_offset(s);
      localparam word_type DEC_OFFSET = subkey_offset(ROUND_COUNT - 1 - s);

      fbc_round u_round (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .prev_stage ((s == 0) ? entry_stage : stages[(s == 0) ? 0 : s - 1]),
         .enc_subkey (key_ff ^ ENC_OFFSET),
         .dec_subkey (key_ff ^ DEC_OFFSET),
         .next_stage (stages[s])
      );

      assign stage_valid[s] = stages[s].valid;
   end

   assign rsp_valid = stages[ROUND_COUNT-1].valid;
   assign rsp_payload.left_result = stages[ROUND_COUNT-1].left_word;
   assign rsp_payload.right_result = stages[ROUND_COUNT-1].right_word;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock)
      reset |=> stage_valid == '0)
      else $error("pipeline valid bits not cleared by reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(stage_valid))
      else $error("pipeline moved while the output was stalled");

   a_entry_taken: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid[0])
      else $error("accepted item did not enter the first round");
`endif

endmodule
